// ===== src/smac_pkg.sv =====
// ----------------------------------------------------------------------------
// smac_pkg
// Shared types, codes and shadow byte helpers for the shadow memory checker.
// ----------------------------------------------------------------------------
package smac_pkg;

  localparam int unsigned CFG_AW = 2;
  localparam int unsigned GIDX_W = 29;
  localparam int unsigned K_W    = 31;

  localparam logic [CFG_AW-1:0] REG_REGION_BASE = 2'd0;

  localparam logic [31:0] REGION_BASE_RST = 32'h2000_0000;
  localparam logic [K_W-1:0] GRANULE_SPACE = 31'h2000_0000;

  typedef enum logic [1:0] {
    ACT_CHECK     = 2'd0,
    ACT_POISON    = 2'd1,
    ACT_UNPOISON  = 2'd2,
    ACT_UNDEFINED = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    CAUSE_NONE    = 3'd0,
    CAUSE_REDZONE = 3'd1,
    CAUSE_FREED   = 3'd2,
    CAUSE_PARTIAL = 3'd3,
    CAUSE_OTHER   = 3'd4
  } cause_t;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_SETUP = 5'b00100,
    ST_WALK  = 5'b01000,
    ST_EVAL  = 5'b10000
  } state_t;

  localparam logic [7:0] SH_POISON_HEAD = 8'hE0;
  localparam logic [7:0] SH_FREED       = 8'hFA;
  localparam logic [7:0] SH_REDZONE_A   = 8'hFB;
  localparam logic [7:0] SH_REDZONE_B   = 8'hF8;
  localparam logic [7:0] SH_REDZONE_LO  = 8'hF1;
  localparam logic [7:0] SH_REDZONE_HI  = 8'hF7;
  localparam logic [7:0] SH_PART_LO     = 8'hE1;
  localparam logic [7:0] SH_PART_HI     = 8'hE7;

  function automatic logic [2:0] classify(input logic [7:0] v);
    logic [2:0] c;
    c = CAUSE_OTHER;
    if (v == 8'h00) begin
      c = CAUSE_NONE;
    end else if (v < 8'h08 || (v >= SH_PART_LO && v <= SH_PART_HI)) begin
      c = CAUSE_PARTIAL;
    end else if (v == SH_FREED) begin
      c = CAUSE_FREED;
    end else if (v == SH_REDZONE_A || v == SH_REDZONE_B ||
                 (v >= SH_REDZONE_LO && v <= SH_REDZONE_HI)) begin
      c = CAUSE_REDZONE;
    end
    return c;
  endfunction

endpackage

// ===== src/smac_shadow_ram.sv =====
// ----------------------------------------------------------------------------
// smac_shadow_ram
// Single write port, single registered read port shadow byte memory.
// ----------------------------------------------------------------------------
module smac_shadow_ram #(
  parameter int unsigned DEPTH = 8192,
  parameter int unsigned AW    = 13
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [7:0]    wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [7:0]    rdata
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/shadow_memory_access_checker_unit.sv =====
// ----------------------------------------------------------------------------
// shadow_memory_access_checker_unit
// Shadow byte map over one memory region with check, poison and unpoison.
// ----------------------------------------------------------------------------
// After reset the block sweeps the shadow memory to zero, one entry per
// cycle, with busy high. An item then passes through a setup state and,
// per granule in the region, a shadow read in the walk state followed by
// evaluation in the evaluate state for a check, or a shadow write in
// the walk state for poison and unpoison; each stretch of granules outside
// the region is passed over in a walk step of its own, and a closing walk
// step follows unless a check stops at a fault. The result shows in the
// cycle after the last of these steps. A zero length item or an undefined
// action is answered the cycle after start. Every item gives exactly one
// result, shown for one cycle with out_valid; the receiver cannot stall it,
// so it must take each result as it appears.
// ----------------------------------------------------------------------------
module shadow_memory_access_checker_unit
  import smac_pkg::*;
#(
  parameter int unsigned REGION_BYTES = 65536
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_action,
  input  logic [31:0]       in_address,
  input  logic [31:0]       in_length,
  input  logic [1:0]        in_access_kind,
  input  logic [7:0]        in_poison_value,
  output logic              out_valid,
  output logic              out_fault,
  output logic [31:0]       out_fault_address,
  output logic [7:0]        out_shadow_byte,
  output logic [2:0]        out_cause,
  output logic [1:0]        out_kind_echo,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned DEPTH = REGION_BYTES / 8;
  localparam int unsigned AW    = $clog2(DEPTH);

  state_t              state_r, state_nxt;
  logic [31:0]         base_r;
  logic [AW-1:0]       clr_cnt_r, clr_cnt_nxt;
  logic [1:0]          act_r, act_nxt;
  logic [1:0]          kind_r, kind_nxt;
  logic [7:0]          pval_r, pval_nxt;
  logic [2:0]          a7_r, a7_nxt;
  logic [31:0]         abase_r, abase_nxt;
  logic [32:0]         total_r, total_nxt;
  logic [GIDX_W-1:0]   idx_r, idx_nxt;
  logic [K_W-1:0]      k_r, k_nxt;
  logic [K_W-1:0]      count_r, count_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic                out_fault_r, out_fault_nxt;
  logic [31:0]         out_faddr_r, out_faddr_nxt;
  logic [7:0]          out_sbyte_r, out_sbyte_nxt;
  logic [2:0]          out_cause_r, out_cause_nxt;
  logic [1:0]          out_kind_r, out_kind_nxt;

  logic                mem_we, mem_re;
  logic [AW-1:0]       mem_waddr, mem_raddr;
  logic [7:0]          mem_wdata, mem_rdata;

  logic                accept;
  logic                cfg_wr;
  logic                head, last, in_region;
  logic [2:0]          lo;
  logic [3:0]          hi;
  logic [K_W-1:0]      k_inc, k_skip;
  logic [GIDX_W-1:0]   idx_inc;
  logic [31:0]         gaddr;
  logic                bad;
  logic [2:0]          off;

  assign accept = start && (state_r == ST_IDLE);
  assign busy   = (state_r != ST_IDLE);
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign prdata = (paddr == REG_REGION_BASE) ? base_r : 32'd0;

  assign head      = (k_r == '0);
  assign k_inc     = k_r + K_W'(1);
  assign k_skip    = k_r + (GRANULE_SPACE - K_W'(idx_r));
  assign idx_inc   = idx_r + GIDX_W'(1);
  assign last      = (k_inc == count_r);
  assign lo        = head ? a7_r : 3'd0;
  assign hi        = (last && total_r[2:0] != 3'd0) ? {1'b0, total_r[2:0]} : 4'd8;
  assign in_region = (idx_r < GIDX_W'(DEPTH));
  assign gaddr     = abase_r + {k_r[GIDX_W-1:0], 3'b000};

  always_comb begin
    bad = 1'b1;
    off = lo;
    if (mem_rdata == 8'h00) begin
      bad = 1'b0;
    end else if (mem_rdata[7:3] == 5'd0) begin
      bad = (hi > {1'b0, mem_rdata[2:0]});
      off = (lo > mem_rdata[2:0]) ? lo : mem_rdata[2:0];
    end else if (mem_rdata >= SH_PART_LO && mem_rdata <= SH_PART_HI) begin
      bad = (lo < mem_rdata[2:0]);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    act_nxt       = act_r;
    kind_nxt      = kind_r;
    pval_nxt      = pval_r;
    a7_nxt        = a7_r;
    abase_nxt     = abase_r;
    total_nxt     = total_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    count_nxt     = count_r;
    out_valid_nxt = 1'b0;
    out_fault_nxt = out_fault_r;
    out_faddr_nxt = out_faddr_r;
    out_sbyte_nxt = out_sbyte_r;
    out_cause_nxt = out_cause_r;
    out_kind_nxt  = out_kind_r;
    mem_we        = 1'b0;
    mem_waddr     = idx_r[AW-1:0];
    mem_wdata     = 8'h00;
    mem_re        = 1'b0;
    mem_raddr     = idx_r[AW-1:0];

    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          act_nxt   = in_action;
          kind_nxt  = in_access_kind;
          pval_nxt  = in_poison_value;
          a7_nxt    = in_address[2:0];
          abase_nxt = {in_address[31:3], 3'b000};
          total_nxt = {30'd0, in_address[2:0]} + {1'b0, in_length};
          idx_nxt   = in_address[31:3] - base_r[31:3];
          k_nxt     = '0;
          if (in_action == ACT_UNDEFINED || in_length == 32'd0) begin
            out_valid_nxt = 1'b1;
            out_fault_nxt = 1'b0;
            out_faddr_nxt = 32'd0;
            out_sbyte_nxt = 8'h00;
            out_cause_nxt = CAUSE_NONE;
            out_kind_nxt  = (in_action == ACT_CHECK) ? in_access_kind : 2'd0;
          end else begin
            state_nxt = ST_SETUP;
          end
        end
      end
      ST_SETUP: begin
        count_nxt = {1'b0, total_r[32:3]} + K_W'(total_r[2:0] != 3'd0);
        state_nxt = ST_WALK;
      end
      ST_WALK: begin
        if (k_r >= count_r) begin
          out_valid_nxt = 1'b1;
          out_fault_nxt = 1'b0;
          out_faddr_nxt = 32'd0;
          out_sbyte_nxt = 8'h00;
          out_cause_nxt = CAUSE_NONE;
          out_kind_nxt  = (act_r == ACT_CHECK) ? kind_r : 2'd0;
          state_nxt     = ST_IDLE;
        end else if (!in_region) begin
          k_nxt   = k_skip;
          idx_nxt = '0;
        end else if (act_r == ACT_CHECK) begin
          mem_re    = 1'b1;
          state_nxt = ST_EVAL;
        end else begin
          mem_we = 1'b1;
          if (head && a7_r != 3'd0) begin
            mem_wdata = (act_r == ACT_POISON) ? {5'd0, a7_r} : (SH_POISON_HEAD | {5'd0, a7_r});
          end else if (act_r == ACT_POISON) begin
            mem_wdata = pval_r;
          end else if (hi == 4'd8) begin
            mem_wdata = 8'h00;
          end else begin
            mem_wdata = {5'd0, total_r[2:0]};
          end
          k_nxt   = k_inc;
          idx_nxt = idx_inc;
        end
      end
      ST_EVAL: begin
        if (bad) begin
          out_valid_nxt = 1'b1;
          out_fault_nxt = 1'b1;
          out_faddr_nxt = {gaddr[31:3], off};
          out_sbyte_nxt = mem_rdata;
          out_cause_nxt = classify(mem_rdata);
          out_kind_nxt  = kind_r;
          state_nxt     = ST_IDLE;
        end else begin
          k_nxt     = k_inc;
          idx_nxt   = idx_inc;
          state_nxt = ST_WALK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      base_r      <= REGION_BASE_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr && paddr == REG_REGION_BASE) begin
        base_r <= pwdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    act_r       <= act_nxt;
    kind_r      <= kind_nxt;
    pval_r      <= pval_nxt;
    a7_r        <= a7_nxt;
    abase_r     <= abase_nxt;
    total_r     <= total_nxt;
    idx_r       <= idx_nxt;
    k_r         <= k_nxt;
    count_r     <= count_nxt;
    out_fault_r <= out_fault_nxt;
    out_faddr_r <= out_faddr_nxt;
    out_sbyte_r <= out_sbyte_nxt;
    out_cause_r <= out_cause_nxt;
    out_kind_r  <= out_kind_nxt;
  end

  smac_shadow_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_shadow_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign out_valid         = out_valid_r;
  assign out_fault         = out_fault_r;
  assign out_fault_address = out_faddr_r;
  assign out_shadow_byte   = out_sbyte_r;
  assign out_cause         = out_cause_r;
  assign out_kind_echo     = out_kind_r;

endmodule
